[sv/lppo_pkg.sv]
// Shared types, widths and codes for the long-press power-off controller.
// No dependencies; imported by every module of the block.
`default_nettype none

package lppo_pkg;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned REL_W      = 16;
  localparam int unsigned STATE_W    = 3;
  localparam int unsigned LED_W      = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 8;

  localparam logic [STATE_W-1:0] ST_ON    = 3'd0;
  localparam logic [STATE_W-1:0] ST_PREP  = 3'd1;
  localparam logic [STATE_W-1:0] ST_READY = 3'd2;
  localparam logic [STATE_W-1:0] ST_SHUT  = 3'd3;
  localparam logic [STATE_W-1:0] ST_OFF   = 3'd4;

  localparam logic [LED_W-1:0] LED_SOLID = 2'd0;
  localparam logic [LED_W-1:0] LED_FAST  = 2'd1;
  localparam logic [LED_W-1:0] LED_SLOW  = 2'd2;
  localparam logic [LED_W-1:0] LED_DARK  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_HOLD       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW = 2'd2;

  localparam logic [TIME_W-1:0] HOLD_RESET    = 32'd3000;
  localparam logic [REL_W-1:0]  RELEASE_RESET = 16'd500;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic              press_event;
    logic              release_event;
    logic              button_held;
    logic              raw_pin_level;
  } in_item_t;

  typedef struct packed {
    logic [STATE_W-1:0] power_state;
    logic [LED_W-1:0]   led_mode;
    logic               accepting_requests;
    logic               sleep_request;
  } out_item_t;

  typedef struct packed {
    logic [TIME_W-1:0] hold_time_ms;
    logic [REL_W-1:0]  release_time_ms;
    logic              pin_active_low;
  } cfg_t;

endpackage

`default_nettype wire

[sv/lppo_cfg.sv]
// Configuration register file: hold time, release time and pin polarity.
// Depends on lppo_pkg.
`default_nettype none

module lppo_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [lppo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lppo_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output lppo_pkg::cfg_t                 cfg
);
  import lppo_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hold_time_ms    <= HOLD_RESET;
      cfg.release_time_ms <= RELEASE_RESET;
      cfg.pin_active_low  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HOLD:       cfg.hold_time_ms    <= cfg_wdata[TIME_W-1:0];
        CFG_RELEASE:    cfg.release_time_ms <= cfg_wdata[REL_W-1:0];
        CFG_ACTIVE_LOW: cfg.pin_active_low  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/lppo_fsm.sv]
// Power-off state machine: state registers and single-pass next-state logic.
// Depends on lppo_pkg.
`default_nettype none

module lppo_fsm (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  lppo_pkg::in_item_t  item,
  input  lppo_pkg::cfg_t      cfg,
  output lppo_pkg::out_item_t result
);
  import lppo_pkg::*;

  logic [STATE_W-1:0] mode, mode_next;
  logic [TIME_W-1:0]  press_start, press_start_next;
  logic [TIME_W-1:0]  stable_start, stable_start_next;
  logic               armed, armed_next;
  logic [LED_W-1:0]   led, led_next;
  logic               sleep;
  logic               pin_active;
  logic [TIME_W-1:0]  stable_base;
  logic [TIME_W-1:0]  hold_elapsed;
  logic [TIME_W-1:0]  stable_elapsed;

  assign pin_active     = item.raw_pin_level ^ cfg.pin_active_low;
  assign stable_base    = (!armed || pin_active) ? item.now_ms : stable_start;
  assign hold_elapsed   = item.now_ms - press_start;
  assign stable_elapsed = item.now_ms - stable_base;

  always_comb begin
    mode_next         = mode;
    press_start_next  = press_start;
    stable_start_next = stable_start;
    armed_next        = armed;
    led_next          = led;
    sleep             = 1'b0;
    case (mode)
      ST_ON: begin
        if (item.press_event) begin
          press_start_next = item.now_ms;
          mode_next        = ST_PREP;
          led_next         = LED_FAST;
        end
      end
      ST_PREP: begin
        if (item.release_event) begin
          mode_next = ST_ON;
          led_next  = LED_SOLID;
        end else if (item.button_held && (hold_elapsed >= cfg.hold_time_ms)) begin
          mode_next = ST_READY;
          led_next  = LED_SLOW;
        end
      end
      ST_READY: begin
        if (item.release_event) begin
          mode_next = ST_SHUT;
        end
      end
      ST_SHUT: begin
        armed_next        = 1'b1;
        stable_start_next = stable_base;
        led_next          = LED_DARK;
        if (stable_elapsed >= {{(TIME_W-REL_W){1'b0}}, cfg.release_time_ms}) begin
          sleep      = 1'b1;
          armed_next = 1'b0;
          mode_next  = ST_OFF;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= ST_ON;
      press_start  <= '0;
      stable_start <= '0;
      armed        <= 1'b0;
      led          <= LED_SOLID;
    end else if (step) begin
      mode         <= mode_next;
      press_start  <= press_start_next;
      stable_start <= stable_start_next;
      armed        <= armed_next;
      led          <= led_next;
    end
  end

  assign result.power_state        = mode_next;
  assign result.led_mode           = led_next;
  assign result.accepting_requests = (mode_next == ST_ON);
  assign result.sleep_request      = sleep;

endmodule

`default_nettype wire

[sv/long_press_power_off_controller.sv]
// Long-press power-off controller, top level.
// Each update passes the input register and then the result register.
// Throughput: one update per cycle unless stalled; next state is combinational.
// Synchronous active-high reset clears state to on, LED solid, and config to defaults.
// Depends on lppo_pkg, lppo_cfg and lppo_fsm.
`default_nettype none

module long_press_power_off_controller (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // now_ms[31:0], press_event[32], release_event[33], button_held[34],
  // raw_pin_level[35], zero fill[39:36]
  input  logic [lppo_pkg::IN_DATA_W-1:0]   s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // power_state[2:0], led_mode[4:3], accepting_requests[5], sleep_request[6],
  // zero fill[7]
  output logic [lppo_pkg::OUT_DATA_W-1:0]  m_tdata,
  input  logic                             cfg_we,
  input  logic [lppo_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lppo_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import lppo_pkg::*;

  cfg_t      cfg;
  in_item_t  in_item;
  logic      in_valid;
  logic      advance;
  out_item_t result;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.now_ms        <= s_tdata[TIME_W-1:0];
      in_item.press_event   <= s_tdata[TIME_W];
      in_item.release_event <= s_tdata[TIME_W+1];
      in_item.button_held   <= s_tdata[TIME_W+2];
      in_item.raw_pin_level <= s_tdata[TIME_W+3];
    end
  end

  lppo_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lppo_fsm u_fsm (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (in_item),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {1'b0, result.sleep_request, result.accepting_requests,
                  result.led_mode, result.power_state};
    end
  end

endmodule

`default_nettype wire

[sv/lppo_checker.sv]
// Port-level checker for the long-press power-off controller, with its bind.
// Depends on lppo_pkg and long_press_power_off_controller.
`default_nettype none

module lppo_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [lppo_pkg::OUT_DATA_W-1:0] m_tdata
);
  import lppo_pkg::*;

  logic [STATE_W-1:0] st;
  logic [LED_W-1:0]   led;

  assign st  = m_tdata[STATE_W-1:0];
  assign led = m_tdata[STATE_W+LED_W-1:STATE_W];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_accepting: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[STATE_W+LED_W] == (st == ST_ON)))
    else $error("accepting_requests disagrees with power_state");

  a_sleep: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[STATE_W+LED_W+1] |-> (st == ST_OFF) && (led == LED_DARK))
    else $error("sleep request outside entry to off");

  a_on_led: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (st == ST_ON) |-> (led == LED_SOLID))
    else $error("LED not solid in on state");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind long_press_power_off_controller lppo_checker u_lppo_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

[dv/tb_long_press_power_off_controller.sv]
`timescale 1ns / 1ps
// Testbench for long_press_power_off_controller: random stream traffic on both sides,
// results compared field by field with a behavioral copy of the power state machine.
// Depends on lppo_pkg and the controller RTL only.

module tb_long_press_power_off_controller;
  import lppo_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t res;
  } step_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // now_ms[31:0], press_event[32], release_event[33], button_held[34], raw_pin_level[35]
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // power_state[2:0], led_mode[4:3], accepting_requests[5], sleep_request[6]
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic [STATE_W-1:0] fsm_mode = ST_ON;
  logic [LED_W-1:0]   led_now = LED_SOLID;
  logic [TIME_W-1:0]  press_t = '0;
  logic [TIME_W-1:0]  stable_t = '0;
  logic               armed = 1'b0;
  logic [TIME_W-1:0]  hold_ms = HOLD_RESET;
  logic [REL_W-1:0]   release_ms = RELEASE_RESET;
  logic               active_low = 1'b1;

  logic [TIME_W-1:0]  wall = '0;
  bit                 steady = 1'b0;
  int                 errors = 0;
  out_item_t          status_due[$];
  step_row_t          drill[$];

  long_press_power_off_controller dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  function automatic out_item_t step_status(input in_item_t it);
    logic sleep;
    sleep = 1'b0;
    case (fsm_mode)
      ST_ON: begin
        if (it.press_event) begin
          press_t = it.now_ms;
          fsm_mode = ST_PREP;
          led_now = LED_FAST;
        end
      end
      ST_PREP: begin
        if (it.release_event) begin
          fsm_mode = ST_ON;
          led_now = LED_SOLID;
        end else if (it.button_held && 32'(it.now_ms - press_t) >= hold_ms) begin
          fsm_mode = ST_READY;
          led_now = LED_SLOW;
        end
      end
      ST_READY: begin
        if (it.release_event) fsm_mode = ST_SHUT;
      end
      ST_SHUT: begin
        if (!armed) begin
          armed = 1'b1;
          stable_t = it.now_ms;
          led_now = LED_DARK;
        end
        if (it.raw_pin_level ^ active_low) stable_t = it.now_ms;
        if (32'(it.now_ms - stable_t) >= 32'(release_ms)) begin
          sleep = 1'b1;
          armed = 1'b0;
          fsm_mode = ST_OFF;
          led_now = LED_DARK;
        end
      end
      default: ;
    endcase
    return {fsm_mode, led_now, fsm_mode == ST_ON, sleep};
  endfunction

  function automatic in_item_t update_of(input logic [TIME_W-1:0] now, input bit p,
                                         input bit r, input bit h, input bit raw);
    in_item_t it;
    it.now_ms = now;
    it.press_event = p;
    it.release_event = r;
    it.button_held = h;
    it.raw_pin_level = raw;
    return it;
  endfunction

  function automatic step_row_t mk_row(input logic [TIME_W-1:0] now, input bit p,
                                       input bit r, input bit h, input bit raw,
                                       input logic [STATE_W-1:0] st,
                                       input logic [LED_W-1:0] led);
    step_row_t row;
    row.item = update_of(now, p, r, h, raw);
    row.typed = 1'b1;
    row.res = {st, led, st == ST_ON, 1'b0};
    return row;
  endfunction

  function automatic int idle_cycles();
    return steady ? 0 : $urandom_range(0, 5);
  endfunction

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("%0t ERROR %s", $time, msg);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_HOLD:       hold_ms = val;
      CFG_RELEASE:    release_ms = val[REL_W-1:0];
      CFG_ACTIVE_LOW: active_low = val[0];
      default: ;
    endcase
  endtask

  task automatic send_update(input in_item_t it, input bit typed, input out_item_t typed_res);
    int gap;
    out_item_t want;
    gap = idle_cycles();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'b0000, it.raw_pin_level, it.button_held, it.release_event,
                it.press_event, it.now_ms};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    want = step_status(it);
    status_due.push_back(typed ? typed_res : want);
  endtask

  // Keep timing inside the hold and release windows so the machine only moves on when told.
  task automatic roll_update(output in_item_t it);
    it.press_event = ($urandom_range(0, 2) == 0);
    it.release_event = ($urandom_range(0, 3) == 0);
    it.button_held = ($urandom_range(0, 1) != 0);
    it.raw_pin_level = ($urandom_range(0, 1) != 0);
    it.now_ms = ($urandom_range(0, 7) == 0 && fsm_mode == ST_ON) ? $urandom()
                                                                : wall + $urandom_range(0, 4000);
    if (fsm_mode == ST_PREP && it.button_held && !it.release_event)
      it.now_ms = press_t + (($urandom_range(0, 3) == 0) ? hold_ms - 1
                                                         : $urandom_range(hold_ms - 1, 0));
    if (fsm_mode == ST_SHUT && armed && it.raw_pin_level == active_low)
      it.now_ms = stable_t + (($urandom_range(0, 3) == 0) ? 32'(release_ms) - 1
                                                          : $urandom_range(release_ms - 1, 0));
    wall = it.now_ms;
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    in_item_t it;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    drill.push_back(mk_row(32'h0000_0000, 0, 0, 0, 1, ST_ON, LED_SOLID));
    drill.push_back(mk_row(32'h0000_0064, 0, 1, 0, 1, ST_ON, LED_SOLID));
    drill.push_back(mk_row(32'hFFFF_FF00, 1, 0, 1, 0, ST_PREP, LED_FAST));
    drill.push_back(mk_row(32'hFFFF_FF00, 1, 0, 1, 0, ST_PREP, LED_FAST));
    // one short of the hold time across the wrap
    drill.push_back(mk_row(32'h0000_0AB7, 0, 0, 1, 0, ST_PREP, LED_FAST));
    drill.push_back(mk_row(32'h0000_0AB8, 0, 0, 0, 0, ST_PREP, LED_FAST));
    drill.push_back(mk_row(32'h0000_0AB8, 0, 1, 1, 0, ST_ON, LED_SOLID));
    drill.push_back(mk_row(32'hFFFF_FFFF, 1, 0, 1, 0, ST_PREP, LED_FAST));
    drill.push_back(mk_row(32'h0000_0BB6, 0, 0, 1, 1, ST_PREP, LED_FAST));
    drill.push_back(mk_row(32'hFFFF_FFFF, 1, 1, 1, 0, ST_ON, LED_SOLID));
    drill.push_back(mk_row(32'h1234_5678, 1, 1, 1, 1, ST_PREP, LED_FAST));
    drill.push_back(mk_row(32'h0000_0000, 0, 1, 0, 0, ST_ON, LED_SOLID));
    drill.push_back(mk_row(32'hFFFF_FFFF, 0, 0, 1, 0, ST_ON, LED_SOLID));
    foreach (drill[i]) send_update(drill[i].item, drill[i].typed, drill[i].res);

    for (int ph = 0; ph < 4; ph++) begin
      settle();
      case (ph)
        0: begin
          write_reg(CFG_HOLD, HOLD_RESET);
          write_reg(CFG_RELEASE, 32'd0);
          write_reg(CFG_ACTIVE_LOW, 32'd1);
        end
        1: begin
          write_reg(CFG_HOLD, 32'hFFFF_FFFF);
          write_reg(CFG_RELEASE, 32'hFFFF_FFFF);
          write_reg(CFG_ACTIVE_LOW, 32'hFFFF_FFFE);
        end
        2: begin
          write_reg(CFG_HOLD, 32'd1);
          write_reg(CFG_RELEASE, $urandom());
          write_reg(CFG_ACTIVE_LOW, $urandom());
          write_reg(CFG_SPARE, $urandom());
        end
        default: begin
          write_reg(CFG_HOLD, $urandom() | 32'd1);
          write_reg(CFG_RELEASE, $urandom());
          write_reg(CFG_ACTIVE_LOW, $urandom());
        end
      endcase
      for (int n = 0; n < 280; n++) begin
        if (n % 40 == 0) steady = ($urandom_range(0, 3) == 0);
        roll_update(it);
        send_update(it, 1'b0, '0);
      end
    end
    steady = 1'b0;

    // zero hold: the first held update in preparing without a release goes ready
    settle();
    write_reg(CFG_HOLD, 32'd0);
    write_reg(CFG_RELEASE, 32'hA5A5_FFFF);
    write_reg(CFG_ACTIVE_LOW, 32'd1);
    send_update(update_of(wall + 1, 0, 1, 0, 1), 1'b0, '0);
    send_update(update_of(wall + 2, 1, 0, 1, 0), 1'b0, '0);
    send_update(update_of(wall + 3, 0, 0, 0, 0), 1'b0, '0);
    send_update(update_of(wall + 4, 0, 1, 1, 0), 1'b0, '0);
    send_update(update_of(wall + 5, 1, 0, 1, 0), 1'b0, '0);
    send_update(update_of(wall + 5, 0, 0, 1, 0), 1'b0, '0);
    wall = wall + 5;
    for (int n = 0; n < 8; n++) begin
      wall = wall + $urandom_range(0, 4000);
      send_update(update_of(wall, $urandom_range(0, 1) != 0, 0, $urandom_range(0, 1) != 0,
                            $urandom_range(0, 1) != 0), 1'b0, '0);
    end
    send_update(update_of(wall, 0, 1, 0, 1), 1'b0, '0);
    for (int n = 0; n < 80; n++) begin
      if (n % 20 == 0) steady = ($urandom_range(0, 2) == 0);
      roll_update(it);
      send_update(it, 1'b0, '0);
    end
    steady = 1'b0;

    // flip pin polarity, then send random updates
    settle();
    write_reg(CFG_ACTIVE_LOW, 32'hFFFF_FFFE);
    for (int n = 0; n < 40; n++) begin
      roll_update(it);
      send_update(it, 1'b0, '0);
    end

    // zero release: sleep at once even with the pin active
    settle();
    write_reg(CFG_RELEASE, 32'hFFFF_0000);
    send_update(update_of(wall + 1, 0, 0, 1, !active_low), 1'b0, '0);
    for (int n = 0; n < 6; n++) begin
      roll_update(it);
      send_update(it, 1'b0, '0);
    end

    settle();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("tb_long_press_power_off_controller passed");
    end else begin
      $display("tb_long_press_power_off_controller failed");
    end
    $finish;
  end

  initial begin
    out_item_t got;
    out_item_t want;
    int hold_off;
    while (rst) @(posedge clk);
    forever begin
      hold_off = idle_cycles();
      if (hold_off > 0) begin
        m_tready <= 1'b0;
        repeat (hold_off) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      // unpack the transfer into power_state, led_mode, accepting_requests, sleep_request
      got = {m_tdata[2:0], m_tdata[4:3], m_tdata[5], m_tdata[6]};
      if (status_due.size() == 0) begin
        flag_error($sformatf("status transfer 0x%02h with nothing expected", m_tdata));
      end else begin
        want = status_due.pop_front();
        if (got.power_state !== want.power_state)
          flag_error($sformatf("power_state expected %0d got %0d",
                               want.power_state, got.power_state));
        if (got.led_mode !== want.led_mode)
          flag_error($sformatf("led_mode expected %0d got %0d", want.led_mode, got.led_mode));
        if (got.accepting_requests !== want.accepting_requests)
          flag_error($sformatf("accepting_requests expected %0d got %0d",
                               want.accepting_requests, got.accepting_requests));
        if (got.sleep_request !== want.sleep_request)
          flag_error($sformatf("sleep_request expected %0d got %0d",
                               want.sleep_request, got.sleep_request));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb_long_press_power_off_controller failed");
    $finish;
  end

endmodule
